[hdl/cbm_pkg.sv]
// Shared types and constants for the cartridge bank mapper with IRQ counter.
// Used by cbm_decode, cbm_irq and cartridge_bank_mapper_irq_unit; no dependencies.
package cbm_pkg;

    localparam logic [15:0] ADDR_MASK   = 16'hF003;
    localparam logic [15:0] ADDR_PRG_16K = 16'h8000;
    localparam logic [15:0] ADDR_PRG_8K  = 16'hC000;
    localparam logic [15:0] ADDR_MIRROR  = 16'hB003;
    localparam logic [15:0] ADDR_IRQ_LATCH = 16'hF000;
    localparam logic [15:0] ADDR_IRQ_CTRL  = 16'hF001;
    localparam logic [15:0] ADDR_IRQ_ACK   = 16'hF002;

    localparam logic [3:0] HI_SND_A = 4'h9;
    localparam logic [3:0] HI_SND_B = 4'hA;
    localparam logic [3:0] HI_SND_C = 4'hB;
    localparam logic [3:0] HI_CHR_LO = 4'hD;
    localparam logic [3:0] HI_CHR_HI = 4'hE;
    localparam logic [1:0] LO_UNUSED = 2'd3;

    localparam logic [7:0] COUNT_TOP = 8'hFF;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_PRG    = 3'd1,
        KIND_CHR    = 3'd2,
        KIND_MIRROR = 3'd3,
        KIND_SOUND  = 3'd4
    } t_map_kind;

    // Declared high field first so map_slot lands in bit 0 when packed.
    typedef struct packed {
        logic       irq_deferred;
        logic       irq_fire;
        logic [7:0] sound_data;
        logic [3:0] sound_reg;
        logic [1:0] mirror_mode;
        logic [1:0] map_span;
        logic [8:0] map_bank;
        logic [2:0] map_slot;
    } t_result;

    // One item handed from the input register to the IRQ logic.
    typedef struct packed {
        logic        step;
        logic        tick;
        logic [15:0] dec_addr;
        logic [7:0]  data;
    } t_irq_req;

endpackage

[hdl/cbm_decode.sv]
// Address decode of a CPU bus write into bank, mirroring and sound reports.
// Depends on cbm_pkg.
module cbm_decode (
    input  logic                i_tick,
    input  logic [15:0]         i_dec_addr,
    input  logic [7:0]          i_data,
    output cbm_pkg::t_map_kind  o_kind,
    output cbm_pkg::t_result    o_res
);

    logic [3:0] hi;
    logic [1:0] lo;
    logic [3:0] snd_base;

    assign hi = i_dec_addr[15:12];
    assign lo = i_dec_addr[1:0];

    always_comb begin
        case (hi)
            cbm_pkg::HI_SND_A: snd_base = 4'd0;
            cbm_pkg::HI_SND_B: snd_base = 4'd3;
            cbm_pkg::HI_SND_C: snd_base = 4'd6;
            default:           snd_base = 4'd0;
        endcase
    end

    always_comb begin
        o_kind = cbm_pkg::KIND_NONE;
        o_res  = '0;
        if (!i_tick) begin
            if (i_dec_addr == cbm_pkg::ADDR_PRG_16K) begin
                // two consecutive 8 KB banks starting at data*2
                o_kind         = cbm_pkg::KIND_PRG;
                o_res.map_slot = 3'd0;
                o_res.map_bank = {i_data, 1'b0};
                o_res.map_span = 2'd2;
            end else if (i_dec_addr == cbm_pkg::ADDR_PRG_8K) begin
                o_kind         = cbm_pkg::KIND_PRG;
                o_res.map_slot = 3'd2;
                o_res.map_bank = {1'b0, i_data};
                o_res.map_span = 2'd1;
            end else if (hi == cbm_pkg::HI_CHR_LO || hi == cbm_pkg::HI_CHR_HI) begin
                o_kind         = cbm_pkg::KIND_CHR;
                o_res.map_slot = {hi == cbm_pkg::HI_CHR_HI, lo};
                o_res.map_bank = {1'b0, i_data};
            end else if (i_dec_addr == cbm_pkg::ADDR_MIRROR) begin
                o_kind            = cbm_pkg::KIND_MIRROR;
                o_res.mirror_mode = i_data[3:2];
            end else if ((hi == cbm_pkg::HI_SND_A || hi == cbm_pkg::HI_SND_B
                          || hi == cbm_pkg::HI_SND_C) && lo != cbm_pkg::LO_UNUSED) begin
                o_kind           = cbm_pkg::KIND_SOUND;
                o_res.sound_reg  = snd_base + {2'b00, lo};
                o_res.sound_data = i_data;
            end
        end
    end

endmodule

[hdl/cbm_irq.sv]
// Scanline IRQ counter: latch, control, acknowledge and mode registers.
// Depends on cbm_pkg.
module cbm_irq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  cbm_pkg::t_irq_req  i_req,
    output logic               o_fire,
    output logic               o_deferred
);

    logic       r_mode;
    logic [7:0] r_latch;
    logic [7:0] r_count;
    logic [1:0] r_ctrl;
    logic [7:0] n_latch;
    logic [7:0] n_count;
    logic [1:0] n_ctrl;
    logic       at_top;

    assign at_top     = (r_count == cbm_pkg::COUNT_TOP);
    assign o_fire     = i_req.step && i_req.tick && r_ctrl[1] && at_top;
    assign o_deferred = o_fire && r_mode;

    always_comb begin
        n_latch = r_latch;
        n_count = r_count;
        n_ctrl  = r_ctrl;
        if (i_req.step) begin
            if (i_req.tick) begin
                if (r_ctrl[1]) begin
                    n_count = at_top ? r_latch : r_count + 8'd1;
                end
            end else begin
                case (i_req.dec_addr)
                    cbm_pkg::ADDR_IRQ_LATCH: n_latch = i_req.data;
                    cbm_pkg::ADDR_IRQ_CTRL: begin
                        n_ctrl = i_req.data[1:0];
                        if (i_req.data[1]) begin
                            n_count = r_latch;
                        end
                    end
                    // acknowledge: enable follows enable-after-acknowledge
                    cbm_pkg::ADDR_IRQ_ACK: n_ctrl = {r_ctrl[0], r_ctrl[0]};
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_latch <= '0;
            r_count <= '0;
            r_ctrl  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            r_latch <= n_latch;
            r_count <= n_count;
            r_ctrl  <= n_ctrl;
        end
    end

endmodule

[hdl/cartridge_bank_mapper_irq_unit.sv]
// Top level of the cartridge bank mapper with scanline IRQ counter.
// Depends on cbm_pkg, cbm_decode and cbm_irq.
//
// Input channel (s_axis): one word is a CPU bus write (tuser = 0, address and
// data in tdata) or a scanline tick (tuser = 1). Output channel (m_axis): one
// result word per input word; tuser carries the map kind, tdata the slot, bank,
// span, mirroring, sound register and IRQ flags.
// The IRQ mode bit is written through i_cfg_wr_en / i_cfg_wr_data; the user
// writes it only while idle, and the block itself does not enforce this.
// A word accepted on s_axis passes through two register stages, the input
// register and the result register, before its result is valid on m_axis.
// Throughput is one word per cycle while the receiver does not stall: an input
// register feeds shallow decode and counter logic into the result register,
// and the IRQ state is updated as a word moves across. When the receiver
// stalls, the result register holds and the input register still takes one
// more word; after that s_axis_tready drops until the result is taken. Reset
// clears both valid flags, the IRQ latch, counter, control and the mode bit.
module cartridge_bank_mapper_irq_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] bus_addr, [23:16] bus_data
    input  logic [23:0] i_s_axis_tdata,
    // [0] opcode
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] map_slot, [11:3] map_bank, [13:12] map_span, [15:14] mirror_mode,
    // [19:16] sound_reg, [27:20] sound_data, [28] irq_fire, [29] irq_deferred
    output logic [31:0] o_m_axis_tdata,
    // [2:0] map_kind
    output logic [2:0]  o_m_axis_tuser
);

    logic                r_in_valid;
    logic                r_in_tick;
    logic [15:0]         r_in_addr;
    logic [7:0]          r_in_data;
    logic                r_out_valid;
    cbm_pkg::t_map_kind  r_out_kind;
    cbm_pkg::t_result    r_out_res;

    logic                advance;
    logic                step;
    logic [15:0]         dec_addr;
    cbm_pkg::t_map_kind  dec_kind;
    cbm_pkg::t_result    dec_res;
    cbm_pkg::t_result    n_out_res;
    cbm_pkg::t_irq_req   irq_req;
    logic                irq_fire;
    logic                irq_deferred;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign dec_addr        = r_in_addr & cbm_pkg::ADDR_MASK;

    cbm_decode u_decode (
        .i_tick     (r_in_tick),
        .i_dec_addr (dec_addr),
        .i_data     (r_in_data),
        .o_kind     (dec_kind),
        .o_res      (dec_res)
    );

    assign irq_req.step     = step;
    assign irq_req.tick     = r_in_tick;
    assign irq_req.dec_addr = dec_addr;
    assign irq_req.data     = r_in_data;

    cbm_irq u_irq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (irq_req),
        .o_fire        (irq_fire),
        .o_deferred    (irq_deferred)
    );

    always_comb begin
        n_out_res              = dec_res;
        n_out_res.irq_fire     = irq_fire;
        n_out_res.irq_deferred = irq_deferred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_tick <= i_s_axis_tuser;
            r_in_addr <= i_s_axis_tdata[15:0];
            r_in_data <= i_s_axis_tdata[23:16];
        end
        if (step) begin
            r_out_kind <= dec_kind;
            r_out_res  <= n_out_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_res};
    assign o_m_axis_tuser  = r_out_kind;

endmodule

[dv/tb_cartridge_bank_mapper_irq_unit.sv]
// Self-checking bench for cartridge_bank_mapper_irq_unit: directed table, then random words.
// Depends on cbm_pkg and the RTL top; results are checked against an in-bench mapper model.
module tb_cartridge_bank_mapper_irq_unit;

    typedef struct packed {
        logic [2:0]       kind;
        logic [1:0]       pad;
        cbm_pkg::t_result res;
    } t_mapper_word;

    typedef struct {
        bit           op;
        logic [15:0]  addr;
        logic [7:0]   data;
        bit           typed;
        t_mapper_word exp;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;

    // sideband that travels with the offered word
    bit           row_typed;
    t_mapper_word row_expect;

    // mapper model state
    bit          deferred_mode;
    logic [7:0]  mdl_latch;
    logic [7:0]  mdl_count;
    logic [1:0]  mdl_ctrl;

    t_mapper_word expected_words[$];
    t_dir_row     dir_rows[$];
    int unsigned  n_mismatch;
    bit           send_gapless;
    bit           recv_gapless;
    int unsigned  recv_stall_req;

    cartridge_bank_mapper_irq_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_mapper_word predict_mapper_word(bit op, logic [15:0] addr,
                                                         logic [7:0] data);
        t_mapper_word w;
        logic [15:0]  dec;
        logic [3:0]   hi;
        logic [1:0]   lo;
        w   = '0;
        dec = addr & cbm_pkg::ADDR_MASK;
        hi  = dec[15:12];
        lo  = dec[1:0];
        if (op) begin
            if (mdl_ctrl[1]) begin
                if (mdl_count == cbm_pkg::COUNT_TOP) begin
                    w.res.irq_fire     = 1'b1;
                    w.res.irq_deferred = deferred_mode;
                    mdl_count          = mdl_latch;
                end else begin
                    mdl_count = mdl_count + 8'd1;
                end
            end
        end else if (dec == cbm_pkg::ADDR_PRG_16K) begin
            w.kind         = cbm_pkg::KIND_PRG;
            w.res.map_bank = {data, 1'b0};
            w.res.map_span = 2'd2;
        end else if (dec == cbm_pkg::ADDR_PRG_8K) begin
            w.kind         = cbm_pkg::KIND_PRG;
            w.res.map_slot = 3'd2;
            w.res.map_bank = {1'b0, data};
            w.res.map_span = 2'd1;
        end else if (hi == cbm_pkg::HI_CHR_LO || hi == cbm_pkg::HI_CHR_HI) begin
            w.kind         = cbm_pkg::KIND_CHR;
            w.res.map_slot = {hi == cbm_pkg::HI_CHR_HI, lo};
            w.res.map_bank = {1'b0, data};
        end else if (dec == cbm_pkg::ADDR_MIRROR) begin
            w.kind            = cbm_pkg::KIND_MIRROR;
            w.res.mirror_mode = data[3:2];
        end else if ((hi == cbm_pkg::HI_SND_A || hi == cbm_pkg::HI_SND_B
                      || hi == cbm_pkg::HI_SND_C) && lo != cbm_pkg::LO_UNUSED) begin
            w.kind           = cbm_pkg::KIND_SOUND;
            w.res.sound_reg  = (hi - cbm_pkg::HI_SND_A) * 4'd3 + {2'b00, lo};
            w.res.sound_data = data;
        end else if (dec == cbm_pkg::ADDR_IRQ_LATCH) begin
            mdl_latch = data;
        end else if (dec == cbm_pkg::ADDR_IRQ_CTRL) begin
            mdl_ctrl = data[1:0];
            if (mdl_ctrl[1])
                mdl_count = mdl_latch;
        end else if (dec == cbm_pkg::ADDR_IRQ_ACK) begin
            // acknowledge: enable follows enable-after-ack
            mdl_ctrl[1] = mdl_ctrl[0];
        end
        return w;
    endfunction

    task automatic check_field(string fname, logic [31:0] e, logic [31:0] a);
        if (a !== e) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch %s: expected 0x%0h got 0x%0h", fname, e, a);
        end
    endtask

    always @(posedge i_clk) begin : accept_mon
        t_mapper_word w;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            w = predict_mapper_word(i_s_axis_tuser, i_s_axis_tdata[15:0],
                                    i_s_axis_tdata[23:16]);
            if (row_typed)
                w = row_expect;
            expected_words.push_back(w);
        end
    end

    always @(posedge i_clk) begin : result_chk
        t_mapper_word e;
        t_mapper_word g;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            g = {o_m_axis_tuser, o_m_axis_tdata};
            if (expected_words.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch: word with none expected, 0x%0h", g);
            end else begin
                e = expected_words.pop_front();
                check_field("map_kind", 32'(e.kind), 32'(g.kind));
                check_field("pad", 32'(e.pad), 32'(g.pad));
                check_field("map_slot", 32'(e.res.map_slot), 32'(g.res.map_slot));
                check_field("map_bank", 32'(e.res.map_bank), 32'(g.res.map_bank));
                check_field("map_span", 32'(e.res.map_span), 32'(g.res.map_span));
                check_field("mirror_mode", 32'(e.res.mirror_mode),
                            32'(g.res.mirror_mode));
                check_field("sound_reg", 32'(e.res.sound_reg), 32'(g.res.sound_reg));
                check_field("sound_data", 32'(e.res.sound_data),
                            32'(g.res.sound_data));
                check_field("irq_fire", 32'(e.res.irq_fire), 32'(g.res.irq_fire));
                check_field("irq_deferred", 32'(e.res.irq_deferred),
                            32'(g.res.irq_deferred));
            end
        end
    end

    // receiver: random hold-off per word, plus an occasional long stall on request
    initial begin : receiver
        int unsigned w;
        i_m_axis_tready <= 1'b0;
        forever begin
            if (recv_stall_req != 0) begin
                w = recv_stall_req;
                recv_stall_req = 0;
            end else begin
                w = recv_gapless ? 0 : $urandom_range(0, 5);
            end
            if (w > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    task automatic send_word(bit op, logic [15:0] addr, logic [7:0] data, bit typed,
                             t_mapper_word exp);
        int unsigned gap;
        gap = send_gapless ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {data, addr};
        i_s_axis_tuser  <= op;
        row_typed       <= typed;
        row_expect      <= exp;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_random_word();
        int unsigned sel;
        logic [3:0]  hi;
        logic [15:0] addr;
        logic [7:0]  data;
        sel  = $urandom_range(0, 99);
        hi   = 4'($urandom_range(8, 15));
        addr = {hi, 10'($urandom), 2'($urandom_range(0, 3))};
        data = 8'($urandom);
        if (sel >= 85)
            addr = 16'($urandom);
        // a latch near the top makes the counter wrap within a few ticks
        if ((addr & cbm_pkg::ADDR_MASK) == cbm_pkg::ADDR_IRQ_LATCH
            && $urandom_range(0, 3) != 0)
            data = 8'hF8 | 8'($urandom_range(0, 7));
        send_word(sel < 40, addr, data, 1'b0, '0);
    endtask

    task automatic drain_words();
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic write_irq_mode(bit v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        deferred_mode = v;
    endtask

    task automatic add_row(bit op, logic [15:0] addr, logic [7:0] data, bit typed,
                           logic [2:0] kind, logic [2:0] slot, logic [8:0] bank,
                           logic [1:0] span, logic [1:0] mirror);
        t_dir_row r;
        r.op   = op;
        r.addr = addr;
        r.data = data;
        r.typed = typed;
        r.exp  = '0;
        r.exp.kind            = kind;
        r.exp.res.map_slot    = slot;
        r.exp.res.map_bank    = bank;
        r.exp.res.map_span    = span;
        r.exp.res.mirror_mode = mirror;
        dir_rows.push_back(r);
    endtask

    initial begin : main
        bit mode;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        row_typed       <= 1'b0;
        row_expect      <= '0;
        deferred_mode   = 1'b0;
        mdl_latch       = '0;
        mdl_count       = '0;
        mdl_ctrl        = '0;
        n_mismatch      = 0;
        send_gapless    = 1'b0;
        recv_gapless    = 1'b0;
        recv_stall_req  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_irq_mode(1'b0);
        //      op addr      data  typed kind                  slot bank    span mirror
        add_row(1, 16'h0000, 8'h00, 1, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0); // tick, IRQ off
        add_row(0, 16'h8000, 8'hFF, 1, cbm_pkg::KIND_PRG,    0, 9'h1FE, 2, 0);
        add_row(0, 16'h8000, 8'h00, 1, cbm_pkg::KIND_PRG,    0, 9'h000, 2, 0);
        add_row(0, 16'hC000, 8'hFF, 1, cbm_pkg::KIND_PRG,    2, 9'h0FF, 1, 0);
        add_row(0, 16'hD000, 8'h00, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0);
        add_row(0, 16'hEFFF, 8'hFF, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0);
        add_row(0, 16'hB003, 8'h0C, 1, cbm_pkg::KIND_MIRROR, 0, 9'h000, 0, 3);
        add_row(0, 16'hBFFF, 8'hF3, 1, cbm_pkg::KIND_MIRROR, 0, 9'h000, 0, 0);
        add_row(0, 16'h9000, 8'hAA, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0);
        add_row(0, 16'hBFF2, 8'h55, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0);
        add_row(0, 16'hA003, 8'h12, 1, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0); // unmapped
        add_row(0, 16'h0000, 8'hFF, 1, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0); // unmapped
        add_row(0, 16'hFFFC, 8'hFE, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0); // latch
        add_row(0, 16'hF001, 8'h02, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0); // enable, load
        add_row(1, 16'hFFFF, 8'hFF, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0);
        add_row(1, 16'h0000, 8'h00, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0); // wraps
        add_row(0, 16'hF001, 8'h01, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0); // off, ack-en
        add_row(1, 16'h0000, 8'h00, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0);
        add_row(0, 16'hF002, 8'h00, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0); // ack enables
        add_row(1, 16'h0000, 8'h00, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0);
        add_row(1, 16'h0000, 8'h00, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0);
        add_row(0, 16'hF001, 8'hFF, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0);
        add_row(0, 16'hF001, 8'h00, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0);
        add_row(0, 16'hF002, 8'hFF, 0, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0); // ack while off
        add_row(0, 16'hFFFF, 8'hFF, 1, cbm_pkg::KIND_NONE,   0, 9'h000, 0, 0); // unmapped
        foreach (dir_rows[k])
            send_word(dir_rows[k].op, dir_rows[k].addr, dir_rows[k].data,
                      dir_rows[k].typed, dir_rows[k].exp);
        i_s_axis_tvalid <= 1'b0;

        for (int p = 0; p < 7; p++) begin
            drain_words();
            repeat (3) @(posedge i_clk);
            mode = (p < 2) ? !p[0] : 1'($urandom_range(0, 1));
            write_irq_mode(mode);
            send_gapless = (p == 2 || p == 4);
            recv_gapless = (p == 2);
            // long receiver stall while words keep coming: input side backs up
            if (p == 4)
                recv_stall_req = 200;
            for (int n = 0; n < 200; n++)
                send_random_word();
            i_s_axis_tvalid <= 1'b0;
        end

        drain_words();
        repeat (10) @(posedge i_clk);
        if (n_mismatch == 0 && expected_words.size() == 0) begin
            $display("PASS cartridge_bank_mapper_irq_unit");
        end else begin
            $display("FAIL cartridge_bank_mapper_irq_unit");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("FAIL cartridge_bank_mapper_irq_unit");
        $finish;
    end

endmodule
